@@ rtl/xxh32_pkg.sv @@
// shared types and constants for the xxhash32 stream hasher
`timescale 1ns / 1ps
package xxh32_pkg;
  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  count;
    logic        last_word;
  } xxh32_req_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] d;
    d = {x, x} << r;
    return d[63:32];
  endfunction
endpackage

@@ rtl/xxh32_front.sv @@
// front end: accepts requests, clamps the byte count, queues them for the core
`timescale 1ns / 1ps
module xxh32_front import xxh32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        q_valid,
  output xxh32_req_t  q_req,
  input  logic        q_take
);
  xxh32_req_t  mem_r [2];
  logic [1:0]  cnt_r;
  logic        wp_r, rp_r;
  logic        push_ok, take_ok;

  assign in_full = cnt_r[1];
  assign push_ok = in_push && !in_full;
  assign q_valid = cnt_r != 2'd0;
  assign take_ok = q_take && q_valid;
  assign q_req   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r].data_word <= in_data_word;
      mem_r[wp_r].count     <= (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
      mem_r[wp_r].last_word <= in_last_word;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (take_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, take_ok};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_req.count <= 3'd4 || !q_valid)
    else $error("count not clamped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !take_ok) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("fill count slip");
endmodule

@@ rtl/xxh32_core.sv @@
// back end: byte stripe buffer, lane mixing, merge, tail fold and avalanche
`timescale 1ns / 1ps
module xxh32_core import xxh32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] seed,
  input  logic        q_valid,
  input  xxh32_req_t  q_req,
  output logic        q_take,
  output logic        res_valid,
  output logic [31:0] res_hash,
  input  logic        res_take
);
  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_MIXA, S_MIXB, S_MERGE, S_WA, S_WB, S_BA, S_BB,
    S_F1, S_F2, S_F3, S_F4, S_OUT
  } state_t;

  state_t      state_r;
  logic [7:0]  buf_r [16];
  logic [31:0] lane_r [4];
  logic [4:0]  fill_r;
  logic [31:0] len_r;
  logic        long_r;
  xxh32_req_t  req_r;
  logic [2:0]  k_r;
  logic [1:0]  lane_i_r;
  logic [31:0] t_r, h_r;
  logic [3:0]  pos_r;
  logic        res_valid_r;
  logic [31:0] res_hash_r;
  logic [31:0] word_at, wp;

  assign word_at = {buf_r[{pos_r[3:2], 2'd3}], buf_r[{pos_r[3:2], 2'd2}],
                    buf_r[{pos_r[3:2], 2'd1}], buf_r[{pos_r[3:2], 2'd0}]};
  assign wp = {buf_r[{lane_i_r, 2'd3}], buf_r[{lane_i_r, 2'd2}],
               buf_r[{lane_i_r, 2'd1}], buf_r[{lane_i_r, 2'd0}]};
  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign res_valid = res_valid_r;
  assign res_hash  = res_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      long_r      <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) lane_r[i] <= '0;
    end else begin
      if (res_take && res_valid_r && state_r != S_OUT) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_req;
            k_r   <= '0;
            if (len_r == 32'd0 && !long_r && fill_r == 5'd0) begin
              lane_r[0] <= seed + PRIME1 + PRIME2;
              lane_r[1] <= seed + PRIME2;
              lane_r[2] <= seed;
              lane_r[3] <= seed - PRIME1;
            end
            state_r <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (k_r < req_r.count) begin
            buf_r[fill_r[3:0]] <= req_r.data_word[{k_r[1:0], 3'd0} +: 8];
            k_r <= k_r + 3'd1;
            if (fill_r == 5'd15) begin
              fill_r   <= '0;
              long_r   <= 1'b1;
              lane_i_r <= '0;
              state_r  <= S_MIXA;
            end else begin
              fill_r <= fill_r + 5'd1;
            end
          end else begin
            len_r <= len_r + {29'd0, req_r.count};
            if (req_r.last_word) state_r <= S_MERGE;
            else state_r <= S_IDLE;
          end
        end
        S_MIXA: begin
          t_r     <= wp * PRIME2;
          state_r <= S_MIXB;
        end
        S_MIXB: begin
          lane_r[lane_i_r] <= rotl(lane_r[lane_i_r] + t_r, 5'd13) * PRIME1;
          lane_i_r <= lane_i_r + 2'd1;
          state_r  <= (lane_i_r == 2'd3) ? S_BYTE : S_MIXA;
        end
        S_MERGE: begin
          h_r <= (long_r ? rotl(lane_r[0], 5'd1) + rotl(lane_r[1], 5'd7)
                         + rotl(lane_r[2], 5'd12) + rotl(lane_r[3], 5'd18)
                         : seed + PRIME5) + len_r;
          pos_r   <= '0;
          state_r <= S_WA;
        end
        S_WA: begin
          if ({1'b0, pos_r} + 5'd4 <= fill_r) begin
            t_r     <= word_at * PRIME3;
            state_r <= S_WB;
          end else begin
            state_r <= S_BA;
          end
        end
        S_WB: begin
          h_r     <= rotl(h_r + t_r, 5'd17) * PRIME4;
          pos_r   <= pos_r + 4'd4;
          state_r <= S_WA;
        end
        S_BA: begin
          if ({1'b0, pos_r} < fill_r) begin
            t_r     <= {24'd0, buf_r[pos_r]} * PRIME5;
            state_r <= S_BB;
          end else begin
            state_r <= S_F1;
          end
        end
        S_BB: begin
          h_r     <= rotl(h_r + t_r, 5'd11) * PRIME1;
          pos_r   <= pos_r + 4'd1;
          state_r <= S_BA;
        end
        S_F1: begin
          h_r <= (h_r ^ (h_r >> 15)) * PRIME2;
          state_r <= S_F2;
        end
        S_F2: begin
          h_r <= (h_r ^ (h_r >> 13)) * PRIME3;
          state_r <= S_F3;
        end
        S_F3: begin
          h_r <= h_r ^ (h_r >> 16);
          fill_r <= '0;
          len_r  <= '0;
          long_r <= 1'b0;
          state_r <= S_F4;
        end
        S_F4: state_r <= S_OUT;
        S_OUT: begin
          if (!res_valid_r || res_take) begin
            res_valid_r <= 1'b1;
            res_hash_r  <= h_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 5'd15)
    else $error("stripe fill out of range");
  assert property (@(posedge clk) disable iff (!rst_n) q_take |=> state_r == S_BYTE)
    else $error("request not started");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_F3) |=> (fill_r == 5'd0 && len_r == 32'd0 && !long_r))
    else $error("message state not cleared");
endmodule

@@ rtl/xxh32_out.sv @@
// result queue between the core and the out_ ports
`timescale 1ns / 1ps
module xxh32_out (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  logic [31:0] res_hash,
  output logic        res_take,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_hash_value
);
  logic        full_r;
  logic [31:0] hash_r;

  assign out_empty      = !full_r;
  assign out_hash_value = hash_r;
  assign res_take       = res_valid && (!full_r || out_pop);

  always_ff @(posedge clk) begin
    if (res_take) hash_r <= res_hash;
    if (!rst_n) full_r <= 1'b0;
    else if (res_take) full_r <= 1'b1;
    else if (out_pop) full_r <= 1'b0;
  end
endmodule

@@ rtl/xxhash32_stream_hasher_unit.sv @@
// top level of the xxhash32 stream hasher
`timescale 1ns / 1ps
// Computes XXH32 of a message given as little-endian 32-bit words, with the seed taken
// from the cfg_ port. The front queues two requests; the core takes each request and
// buffers its valid bytes one at a time, and mixes each completed 16-byte stripe per lane
// (multiply, then rotate and multiply). A last request adds the merge, a multiply and a
// rotate-and-multiply step per buffered whole word and per leftover byte, and the
// avalanche, before the hash reaches the one-entry result queue.
module xxhash32_stream_hasher_unit import xxh32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_hash_value
);
  logic [31:0] seed_r;
  logic        q_valid, q_take, res_valid, res_take;
  xxh32_req_t  q_req;
  logic [31:0] res_hash;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= '0;
    else if (cfg_valid) seed_r <= cfg_seed;
  end

  xxh32_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_word, .in_valid_bytes, .in_last_word,
    .q_valid, .q_req, .q_take
  );
  xxh32_core u_core (
    .clk, .rst_n, .seed(seed_r), .q_valid, .q_req, .q_take,
    .res_valid, .res_hash, .res_take
  );
  xxh32_out u_out (
    .clk, .rst_n, .res_valid, .res_hash, .res_take, .out_empty, .out_pop, .out_hash_value
  );
endmodule
